[rtl/pid_dz_pkg.sv]
// ----------------------------------------------------------------------------
// pid_dz_pkg
// Shared widths, register indexes, reset values and zone codes for the
// PID step with deadband zone.
// ----------------------------------------------------------------------------
package pid_dz_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int SUM_WIDTH_DEF    = 40;

  localparam int GAIN_W     = 16;
  localparam int DRIVE_W    = 32;
  localparam int FRAC_SHIFT = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int BAND_W     = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [BAND_W-1:0]    band_t;

  localparam cfg_idx_t REG_TARGET     = 3'd0;
  localparam cfg_idx_t REG_GAIN_PROP  = 3'd1;
  localparam cfg_idx_t REG_GAIN_INTEG = 3'd2;
  localparam cfg_idx_t REG_GAIN_DERIV = 3'd3;
  localparam cfg_idx_t REG_DEADBAND   = 3'd4;

  localparam int RST_TARGET     = 32768;
  localparam int RST_GAIN_PROP  = 256;
  localparam int RST_GAIN_INTEG = 26;
  localparam int RST_GAIN_DERIV = 2560;
  localparam int RST_DEADBAND   = 328;

  localparam band_t BAND_BELOW  = 2'd0;
  localparam band_t BAND_INSIDE = 2'd1;
  localparam band_t BAND_ABOVE  = 2'd2;

endpackage

[rtl/pid_dz_cfg.sv]
// ----------------------------------------------------------------------------
// pid_dz_cfg
// Configuration register file: target distance, three gains and deadband.
// ----------------------------------------------------------------------------
module pid_dz_cfg
  import pid_dz_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int CFG_W        = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  cfg_idx_t                  cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  output logic [SAMPLE_WIDTH-1:0]   target,
  output logic [GAIN_W-1:0]         gain_prop,
  output logic [GAIN_W-1:0]         gain_integ_dt,
  output logic [GAIN_W-1:0]         gain_deriv_per_dt,
  output logic [SAMPLE_WIDTH-2:0]   deadband
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target            <= SAMPLE_WIDTH'(RST_TARGET);
      gain_prop         <= GAIN_W'(RST_GAIN_PROP);
      gain_integ_dt     <= GAIN_W'(RST_GAIN_INTEG);
      gain_deriv_per_dt <= GAIN_W'(RST_GAIN_DERIV);
      deadband          <= (SAMPLE_WIDTH-1)'(RST_DEADBAND);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TARGET:     target            <= cfg_data[SAMPLE_WIDTH-1:0];
        REG_GAIN_PROP:  gain_prop         <= cfg_data[GAIN_W-1:0];
        REG_GAIN_INTEG: gain_integ_dt     <= cfg_data[GAIN_W-1:0];
        REG_GAIN_DERIV: gain_deriv_per_dt <= cfg_data[GAIN_W-1:0];
        REG_DEADBAND:   deadband          <= cfg_data[SAMPLE_WIDTH-2:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/pid_dz_err.sv]
// ----------------------------------------------------------------------------
// pid_dz_err
// Error front end: error register, saturating integral, difference from the
// previous error and deadband zone.
// ----------------------------------------------------------------------------
module pid_dz_err
  import pid_dz_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [SAMPLE_WIDTH-1:0]        measured,
  input  logic [SAMPLE_WIDTH-1:0]        target,
  input  logic [SAMPLE_WIDTH-2:0]        deadband,
  output logic                           b_valid,
  input  logic                           b_ready,
  output logic signed [SAMPLE_WIDTH:0]   b_err,
  output logic signed [SAMPLE_WIDTH+1:0] b_diff,
  output logic signed [SUM_WIDTH-1:0]    b_sum,
  output band_t                          b_band
);

  localparam int EW = SAMPLE_WIDTH + 1;
  localparam int AW = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;

  logic                    a_valid;
  logic signed [EW-1:0]    a_err;
  logic                    a_adv;
  logic                    b_adv;

  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [EW-1:0]        last_error;
  logic signed [AW-1:0]        sum_wide;
  logic signed [AW-1:0]        sum_max;
  logic signed [AW-1:0]        sum_min;
  logic signed [SUM_WIDTH-1:0] error_sum_next;
  logic signed [EW-1:0]        db_s;
  band_t                       band_next;

  assign b_adv    = !b_valid || b_ready;
  assign a_adv    = !a_valid || b_adv;
  assign in_ready = a_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_adv) begin
      a_err <= $signed({target[SAMPLE_WIDTH-1], target})
             - $signed({measured[SAMPLE_WIDTH-1], measured});
    end
  end

  // The integral saturates at the signed limits of its own width.
  assign sum_wide = AW'(error_sum) + AW'(a_err);
  assign sum_max  = AW'({1'b0, {(SUM_WIDTH-1){1'b1}}});
  assign sum_min  = -sum_max - AW'(1);

  always_comb begin
    if (sum_wide > sum_max) begin
      error_sum_next = SUM_WIDTH'(sum_max);
    end else if (sum_wide < sum_min) begin
      error_sum_next = SUM_WIDTH'(sum_min);
    end else begin
      error_sum_next = SUM_WIDTH'(sum_wide);
    end
  end

  assign db_s = $signed({2'b00, deadband});

  always_comb begin
    if (a_err < -db_s) begin
      band_next = BAND_BELOW;
    end else if (a_err > db_s) begin
      band_next = BAND_ABOVE;
    end else begin
      band_next = BAND_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      error_sum  <= '0;
      last_error <= '0;
    end else begin
      if (b_adv) begin
        b_valid <= a_valid;
      end
      if (a_valid && b_adv) begin
        error_sum  <= error_sum_next;
        last_error <= a_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && b_adv) begin
      b_err  <= a_err;
      b_diff <= (EW+1)'(a_err) - (EW+1)'(last_error);
      b_band <= band_next;
    end
  end

  assign b_sum = error_sum;

  // The stored previous error always equals the error held in the output stage.
  assert property (@(posedge clk) disable iff (rst) b_valid |-> last_error == b_err)
    else $error("last_error out of step with staged error");

  assert property (@(posedge clk) disable iff (rst)
    a_valid && b_adv |=> b_valid && b_err == $past(a_err))
    else $error("error stage lost or altered an item");

  assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_adv |=> a_valid && $stable(a_err))
    else $error("error register changed while stalled");

endmodule

[rtl/pid_dz_mac.sv]
// ----------------------------------------------------------------------------
// pid_dz_mac
// Gain products, term sum, floor shift to Q.16 and 32-bit saturation,
// ending in the result register.
// ----------------------------------------------------------------------------
module pid_dz_mac
  import pid_dz_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [GAIN_W-1:0]              gain_prop,
  input  logic [GAIN_W-1:0]              gain_integ_dt,
  input  logic [GAIN_W-1:0]              gain_deriv_per_dt,
  input  logic                           b_valid,
  output logic                           b_ready,
  input  logic signed [SAMPLE_WIDTH:0]   b_err,
  input  logic signed [SAMPLE_WIDTH+1:0] b_diff,
  input  logic signed [SUM_WIDTH-1:0]    b_sum,
  input  band_t                          b_band,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [DRIVE_W-1:0]             drive,
  output band_t                          band,
  output logic [SAMPLE_WIDTH:0]          err_now
);

  localparam int EW   = SAMPLE_WIDTH + 1;
  localparam int DW   = SAMPLE_WIDTH + 2;
  localparam int PPW  = GAIN_W + EW;
  localparam int DPW  = GAIN_W + DW;
  localparam int IPW  = GAIN_W + SUM_WIDTH;
  localparam int ICW  = (IPW > 62) ? 63 : IPW;
  localparam int TW   = (ICW > DPW) ? ICW : DPW;
  localparam int TOTW = TW + 2;

  logic c_valid;
  logic c_adv;
  logic o_adv;

  logic signed [PPW-1:0] p_prod;
  logic signed [DPW-1:0] d_prod;
  logic signed [IPW-1:0] i_prod;
  logic signed [ICW-1:0] i_term;

  logic signed [TW-1:0]  c_p;
  logic signed [TW-1:0]  c_i;
  logic signed [TW-1:0]  c_d;
  logic signed [EW-1:0]  c_err;
  band_t                 c_band;

  logic signed [TOTW-1:0] total;
  logic signed [TOTW-1:0] shifted;
  logic signed [TOTW-1:0] drv_max;
  logic signed [TOTW-1:0] drv_min;
  logic [DRIVE_W-1:0]     drive_next;

  assign o_adv   = !out_valid || out_ready;
  assign c_adv   = !c_valid || o_adv;
  assign b_ready = c_adv;

  assign p_prod = PPW'($signed(gain_prop)) * PPW'(b_err);
  assign d_prod = DPW'($signed(gain_deriv_per_dt)) * DPW'(b_diff);
  assign i_prod = IPW'($signed(gain_integ_dt)) * IPW'(b_sum);

  // A very wide integral term is clamped to 2^61 in magnitude; such a term
  // already pushes the drive into saturation.
  generate
    if (IPW > 62) begin : g_clamp
      logic signed [IPW-1:0] lim;
      assign lim = $signed({{(IPW-62){1'b0}}, 1'b1, 61'b0});
      always_comb begin
        if (i_prod > lim) begin
          i_term = ICW'(lim);
        end else if (i_prod < -lim) begin
          i_term = ICW'(-lim);
        end else begin
          i_term = ICW'(i_prod);
        end
      end
    end else begin : g_direct
      assign i_term = i_prod;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && c_adv) begin
      c_p    <= TW'(p_prod);
      c_i    <= TW'(i_term);
      c_d    <= TW'(d_prod);
      c_err  <= b_err;
      c_band <= b_band;
    end
  end

  // Arithmetic shift of a signed sum rounds toward minus infinity.
  assign total   = TOTW'(c_p) + TOTW'(c_i) + TOTW'(c_d);
  assign shifted = total >>> FRAC_SHIFT;
  assign drv_max = $signed({{(TOTW-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}});
  assign drv_min = $signed({{(TOTW-DRIVE_W+1){1'b1}}, {(DRIVE_W-1){1'b0}}});

  always_comb begin
    if (shifted > drv_max) begin
      drive_next = DRIVE_W'(drv_max);
    end else if (shifted < drv_min) begin
      drive_next = DRIVE_W'(drv_min);
    end else begin
      drive_next = DRIVE_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_adv) begin
      out_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_valid && o_adv) begin
      drive   <= drive_next;
      band    <= c_band;
      err_now <= c_err;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    c_valid && o_adv |=> out_valid && err_now == $past(c_err))
    else $error("product stage lost or altered an item");

  assert property (@(posedge clk) disable iff (rst)
    c_valid && !o_adv |=> c_valid && $stable(c_p) && $stable(c_i) && $stable(c_d))
    else $error("product stage changed while stalled");

  assert property (@(posedge clk) disable iff (rst)
    c_valid && !o_adv |-> !b_ready)
    else $error("product stage accepted while full and stalled");

endmodule

[rtl/pid_step_with_deadband_zone.sv]
// ----------------------------------------------------------------------------
// pid_step_with_deadband_zone
// Discrete PID step with saturating integral, Q8.8 gains, floor shift to
// Q.16 with 32-bit saturation, and a below/within/above deadband zone.
//
//   Channel  Signals                                   Direction
//   in       in_valid, in_ready, measured              into the block
//   out      out_valid, out_ready, drive, band,        out of the block
//            err_now
//   cfg      cfg_valid, cfg_ready, cfg_index,          into the block
//            cfg_data
//
// One measurement is accepted per cycle while the output is not stalled; its
// result passes in turn through the error, integral, product and result
// registers. The integral and previous error update in the second
// stage, in order. Reset clears the pipeline and state and loads the register
// defaults. A stalled output holds the whole pipeline; bubbles are squeezed out.
// Configuration writes complete in the cycle they are presented.
// ----------------------------------------------------------------------------
module pid_step_with_deadband_zone
  import pid_dz_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int SUM_WIDTH    = SUM_WIDTH_DEF,
  parameter int CFG_W        = (SAMPLE_WIDTH > GAIN_W) ? SAMPLE_WIDTH : GAIN_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] measured,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [DRIVE_W-1:0]      drive,
  output band_t                   band,
  output logic [SAMPLE_WIDTH:0]   err_now,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  cfg_idx_t                cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  logic [SAMPLE_WIDTH-1:0]        target;
  logic [GAIN_W-1:0]              gain_prop;
  logic [GAIN_W-1:0]              gain_integ_dt;
  logic [GAIN_W-1:0]              gain_deriv_per_dt;
  logic [SAMPLE_WIDTH-2:0]        deadband;

  logic                           b_valid;
  logic                           b_ready;
  logic signed [SAMPLE_WIDTH:0]   b_err;
  logic signed [SAMPLE_WIDTH+1:0] b_diff;
  logic signed [SUM_WIDTH-1:0]    b_sum;
  band_t                          b_band;

  pid_dz_cfg #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .CFG_W        (CFG_W)
  ) u_cfg (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .target            (target),
    .gain_prop         (gain_prop),
    .gain_integ_dt     (gain_integ_dt),
    .gain_deriv_per_dt (gain_deriv_per_dt),
    .deadband          (deadband)
  );

  pid_dz_err #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_err (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .measured  (measured),
    .target    (target),
    .deadband  (deadband),
    .b_valid   (b_valid),
    .b_ready   (b_ready),
    .b_err     (b_err),
    .b_diff    (b_diff),
    .b_sum     (b_sum),
    .b_band    (b_band)
  );

  pid_dz_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_mac (
    .clk               (clk),
    .rst               (rst),
    .gain_prop         (gain_prop),
    .gain_integ_dt     (gain_integ_dt),
    .gain_deriv_per_dt (gain_deriv_per_dt),
    .b_valid           (b_valid),
    .b_ready           (b_ready),
    .b_err             (b_err),
    .b_diff            (b_diff),
    .b_sum             (b_sum),
    .b_band            (b_band),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .drive             (drive),
    .band              (band),
    .err_now           (err_now)
  );

endmodule
